[hdl/tmcs_pkg.sv]
// ----------------------------------------------------------------------------
// tmcs_pkg
// Shared types and constants of the tile map chunk store: command and status
// codes, request and response words, and the control and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmcs_pkg;

   localparam int MAX_MAP_DIM   = 64;
   localparam int MAX_CHUNK_DIM = 8;

   localparam int MAP_AW      = $clog2(MAX_MAP_DIM);
   localparam int CHUNK_AW    = $clog2(MAX_CHUNK_DIM);
   localparam int MEM_AW      = 2 * MAP_AW;
   localparam int MEM_DEPTH   = 1 << MEM_AW;
   localparam int DIM_W       = 7;
   localparam int CDIM_W      = 4;
   localparam int LAYER_CNT_W = 9;
   localparam int CELL_W      = 8;
   localparam int GEN_W       = 64;
   localparam int BASE_W      = MAP_AW + CHUNK_AW;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 9;
   localparam int DIV_STEPS   = MAP_AW;

   typedef enum logic [1:0] {
      CMD_WRITE_CELL,
      CMD_READ_CELL,
      CMD_READ_CHUNK,
      CMD_READ_GEN
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_CELL_OOB,
      STAT_LAYER_BAD,
      STAT_CHUNK_OOB
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH    = 3'd0,
      CSR_MAP_HEIGHT   = 3'd1,
      CSR_CHUNK_WIDTH  = 3'd2,
      CSR_CHUNK_HEIGHT = 3'd3,
      CSR_LAYER_COUNT  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      RSP_STATUS,
      RSP_CELL,
      RSP_GEN,
      RSP_CHUNK
   } rsp_sel_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_BASE,
      S_EVAL,
      S_DIV,
      S_GEN_RD,
      S_GEN_WR,
      S_CELL_OUT,
      S_GEN_OUT,
      S_CHUNK
   } state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [MAP_AW-1:0] col;
      logic [MAP_AW-1:0] row;
      logic [CELL_W-1:0] layer_value;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [CELL_W-1:0] cell_value;
      logic [GEN_W-1:0]  generation;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic        capture;
      logic        base_load;
      logic        clear;
      logic        cell_write;
      logic        cell_read;
      logic        chunk_start;
      logic        chunk_adv;
      logic        div_start;
      logic        gen_read_cmd;
      logic        gen_read_rmw;
      logic        gen_inc;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
      status_type  rsp_status;
   } ctrl_type;

   typedef struct packed {
      logic    clear_done;
      cmd_type cmd;
      logic    cell_oob;
      logic    layer_bad;
      logic    chunk_oob;
      logic    div_done;
      logic    chunk_end;
      logic    rsp_free;
   } stat_type;

endpackage

[hdl/tmcs_div.sv]
// ----------------------------------------------------------------------------
// tmcs_div
// Two-lane restoring divider. Divides a cell row and a cell column by the
// chunk height and width, one quotient bit per lane each cycle.
// ----------------------------------------------------------------------------
module tmcs_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tmcs_pkg::MAP_AW-1:0]         dividend_row,
   input  logic [tmcs_pkg::MAP_AW-1:0]         dividend_col,
   input  logic [tmcs_pkg::CDIM_W-1:0]         divisor_row,
   input  logic [tmcs_pkg::CDIM_W-1:0]         divisor_col,
   output logic [tmcs_pkg::MAP_AW-1:0]         quotient_row,
   output logic [tmcs_pkg::MAP_AW-1:0]         quotient_col,
   output logic                                done
);

   localparam int REM_W = tmcs_pkg::CDIM_W - 1;
   localparam int CNT_W = $clog2(tmcs_pkg::DIV_STEPS);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tmcs_pkg::MAP_AW-1:0] row_dq_ff, row_dq_in, col_dq_ff, col_dq_in;
   logic [REM_W-1:0]            row_rem_ff, row_rem_in, col_rem_ff, col_rem_in;

   function automatic logic [REM_W+tmcs_pkg::MAP_AW-1:0] div_step(
      input logic [REM_W-1:0]            rem,
      input logic [tmcs_pkg::MAP_AW-1:0] dq,
      input logic [tmcs_pkg::CDIM_W-1:0] d
   );
      logic [tmcs_pkg::CDIM_W-1:0] trial;
      logic                        ge;
      logic [REM_W-1:0]            rem_nx;
      trial  = {rem, dq[tmcs_pkg::MAP_AW-1]};
      ge     = (trial >= d);
      rem_nx = ge ? REM_W'(trial - d) : REM_W'(trial);
      return {rem_nx, dq[tmcs_pkg::MAP_AW-2:0], ge};
   endfunction

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      row_dq_in  = row_dq_ff;
      col_dq_in  = col_dq_ff;
      row_rem_in = row_rem_ff;
      col_rem_in = col_rem_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         row_dq_in  = dividend_row;
         col_dq_in  = dividend_col;
         row_rem_in = '0;
         col_rem_in = '0;
      end else if (busy_ff) begin
         {row_rem_in, row_dq_in} = div_step(row_rem_ff, row_dq_ff, divisor_row);
         {col_rem_in, col_dq_in} = div_step(col_rem_ff, col_dq_ff, divisor_col);
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(tmcs_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      row_dq_ff  <= row_dq_in;
      col_dq_ff  <= col_dq_in;
      row_rem_ff <= row_rem_in;
      col_rem_ff <= col_rem_in;
   end

   assign quotient_row = row_dq_ff;
   assign quotient_col = col_dq_ff;
   assign done         = done_ff;

endmodule

[hdl/tmcs_dp.sv]
// ----------------------------------------------------------------------------
// tmcs_dp
// Datapath: configuration registers, captured request, cell and generation
// memories with their clearing sweep, chunk scan counters and the response
// register.
// ----------------------------------------------------------------------------
module tmcs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  tmcs_pkg::req_type                   req_data,
   input  logic                                rsp_ready,
   input  logic                                csr_we,
   input  logic [tmcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tmcs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  tmcs_pkg::ctrl_type                  ctrl,
   output tmcs_pkg::stat_type                  stat,
   output logic                                rsp_valid,
   output tmcs_pkg::rsp_type                   rsp_data
);

   localparam int MAW = tmcs_pkg::MAP_AW;
   localparam int CAW = tmcs_pkg::CHUNK_AW;
   localparam int BW  = tmcs_pkg::BASE_W;
   localparam int DW  = tmcs_pkg::DIM_W;
   localparam int CDW = tmcs_pkg::CDIM_W;

   logic [DW-1:0]                      map_width_ff, map_height_ff;
   logic [CDW-1:0]                     chunk_width_ff, chunk_height_ff;
   logic [tmcs_pkg::LAYER_CNT_W-1:0]   layer_count_ff;
   tmcs_pkg::req_type                  item_ff;
   logic [BW-1:0]                      wr_base_ff, wc_base_ff;
   logic [CAW-1:0]                     lr_ff, lr_in, lc_ff, lc_in;
   logic                               pad_ff;
   logic [tmcs_pkg::MEM_AW-1:0]        clr_addr_ff;
   logic [tmcs_pkg::CELL_W-1:0]        cell_rd_ff;
   logic [tmcs_pkg::GEN_W-1:0]         gen_rd_ff;
   tmcs_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic [tmcs_pkg::CELL_W-1:0]        cell_mem [tmcs_pkg::MEM_DEPTH];
   logic [tmcs_pkg::GEN_W-1:0]         gen_mem  [tmcs_pkg::MEM_DEPTH];

   logic [DW-1:0]                      mw, mh;
   logic [CDW-1:0]                     cw, ch;
   logic [CAW-1:0]                     cw_m1, ch_m1, lr_nx, lc_nx;
   logic                               at_end, in_map;
   logic [BW-1:0]                      wr, wc;
   logic [MAW-1:0]                     q_row, q_col;
   logic                               div_done;
   logic                               cell_we, cell_re, gen_we, gen_re;
   logic [tmcs_pkg::MEM_AW-1:0]        cell_waddr, cell_raddr, gen_waddr, gen_raddr;
   logic [tmcs_pkg::CELL_W-1:0]        cell_wdata;
   logic [tmcs_pkg::GEN_W-1:0]         gen_wdata;

   function automatic logic [DW-1:0] clamp_map(input logic [DW-1:0] v);
      if (v == '0)
         return DW'(1);
      if (v > DW'(tmcs_pkg::MAX_MAP_DIM))
         return DW'(tmcs_pkg::MAX_MAP_DIM);
      return v;
   endfunction

   function automatic logic [CDW-1:0] clamp_chunk(input logic [CDW-1:0] v);
      if (v == '0)
         return CDW'(1);
      if (v > CDW'(tmcs_pkg::MAX_CHUNK_DIM))
         return CDW'(tmcs_pkg::MAX_CHUNK_DIM);
      return v;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff    <= DW'(tmcs_pkg::MAX_MAP_DIM);
         map_height_ff   <= DW'(tmcs_pkg::MAX_MAP_DIM);
         chunk_width_ff  <= CDW'(tmcs_pkg::MAX_CHUNK_DIM);
         chunk_height_ff <= CDW'(tmcs_pkg::MAX_CHUNK_DIM);
         layer_count_ff  <= tmcs_pkg::LAYER_CNT_W'(256);
      end else if (csr_we) begin
         case (csr_index)
            tmcs_pkg::CSR_MAP_WIDTH:    map_width_ff    <= csr_wdata[DW-1:0];
            tmcs_pkg::CSR_MAP_HEIGHT:   map_height_ff   <= csr_wdata[DW-1:0];
            tmcs_pkg::CSR_CHUNK_WIDTH:  chunk_width_ff  <= csr_wdata[CDW-1:0];
            tmcs_pkg::CSR_CHUNK_HEIGHT: chunk_height_ff <= csr_wdata[CDW-1:0];
            tmcs_pkg::CSR_LAYER_COUNT:  layer_count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign mw    = clamp_map(map_width_ff);
   assign mh    = clamp_map(map_height_ff);
   assign cw    = clamp_chunk(chunk_width_ff);
   assign ch    = clamp_chunk(chunk_height_ff);
   assign cw_m1 = CAW'(cw - CDW'(1));
   assign ch_m1 = CAW'(ch - CDW'(1));

   always_ff @(posedge clock) begin
      if (ctrl.capture)
         item_ff <= req_data;
      if (ctrl.base_load) begin
         wr_base_ff <= BW'({{(BW-MAW){1'b0}}, item_ff.row} * {{(BW-CDW){1'b0}}, ch});
         wc_base_ff <= BW'({{(BW-MAW){1'b0}}, item_ff.col} * {{(BW-CDW){1'b0}}, cw});
      end
   end

   // A chunk lies outside the grid exactly when its first cell lies outside the map.
   assign stat.chunk_oob = (wc_base_ff >= {{(BW-DW){1'b0}}, mw}) ||
                           (wr_base_ff >= {{(BW-DW){1'b0}}, mh});
   assign stat.cell_oob  = ({1'b0, item_ff.col} >= mw) || ({1'b0, item_ff.row} >= mh);
   assign stat.layer_bad = ({1'b0, item_ff.layer_value} >= layer_count_ff);
   assign stat.cmd       = item_ff.cmd;

   // Chunk scan: the next cell's address is read while the current word is loaded.
   assign at_end = (lr_ff == ch_m1) && (lc_ff == cw_m1);
   assign lc_nx  = (lc_ff == cw_m1) ? '0 : lc_ff + CAW'(1);
   assign lr_nx  = (lc_ff == cw_m1) ? lr_ff + CAW'(1) : lr_ff;
   assign lr_in  = ctrl.chunk_start ? '0 : lr_nx;
   assign lc_in  = ctrl.chunk_start ? '0 : lc_nx;
   assign wr     = wr_base_ff + {{(BW-CAW){1'b0}}, lr_in};
   assign wc     = wc_base_ff + {{(BW-CAW){1'b0}}, lc_in};
   assign in_map = (wr < {{(BW-DW){1'b0}}, mh}) && (wc < {{(BW-DW){1'b0}}, mw});

   always_ff @(posedge clock) begin
      if (ctrl.chunk_start || ctrl.chunk_adv) begin
         lr_ff  <= lr_in;
         lc_ff  <= lc_in;
         pad_ff <= !in_map;
      end
   end

   assign stat.chunk_end = at_end;

   always_ff @(posedge clock) begin
      if (reset)
         clr_addr_ff <= '0;
      else if (ctrl.clear)
         clr_addr_ff <= clr_addr_ff + tmcs_pkg::MEM_AW'(1);
   end

   assign stat.clear_done = (clr_addr_ff == {tmcs_pkg::MEM_AW{1'b1}});

   tmcs_div u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (ctrl.div_start),
      .dividend_row (item_ff.row),
      .dividend_col (item_ff.col),
      .divisor_row  (ch),
      .divisor_col  (cw),
      .quotient_row (q_row),
      .quotient_col (q_col),
      .done         (div_done)
   );

   assign stat.div_done = div_done;

   assign cell_we    = ctrl.clear || ctrl.cell_write;
   assign cell_waddr = ctrl.clear ? clr_addr_ff : {item_ff.row, item_ff.col};
   assign cell_wdata = ctrl.clear ? '0 : item_ff.layer_value;
   assign cell_re    = ctrl.cell_read || ctrl.chunk_start || ctrl.chunk_adv;
   assign cell_raddr = ctrl.cell_read ? {item_ff.row, item_ff.col} : {wr[MAW-1:0], wc[MAW-1:0]};

   always_ff @(posedge clock) begin
      if (cell_we)
         cell_mem[cell_waddr] <= cell_wdata;
      if (cell_re)
         cell_rd_ff <= cell_mem[cell_raddr];
   end

   assign gen_we    = ctrl.clear || ctrl.gen_inc;
   assign gen_waddr = ctrl.clear ? clr_addr_ff : {q_row, q_col};
   assign gen_wdata = ctrl.clear ? '0 : gen_rd_ff + tmcs_pkg::GEN_W'(1);
   assign gen_re    = ctrl.gen_read_cmd || ctrl.gen_read_rmw;
   assign gen_raddr = ctrl.gen_read_cmd ? {item_ff.row, item_ff.col} : {q_row, q_col};

   always_ff @(posedge clock) begin
      if (gen_we)
         gen_mem[gen_waddr] <= gen_wdata;
      if (gen_re)
         gen_rd_ff <= gen_mem[gen_raddr];
   end

   always_comb begin
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      if (ctrl.rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = tmcs_pkg::STAT_OK;
         rsp_in.cell_value = '0;
         rsp_in.generation = '0;
         rsp_in.last       = 1'b1;
         case (ctrl.rsp_sel)
            tmcs_pkg::RSP_STATUS: rsp_in.status     = ctrl.rsp_status;
            tmcs_pkg::RSP_CELL:   rsp_in.cell_value = cell_rd_ff;
            tmcs_pkg::RSP_GEN:    rsp_in.generation = gen_rd_ff;
            tmcs_pkg::RSP_CHUNK: begin
               rsp_in.cell_value = pad_ff ? '0 : cell_rd_ff;
               rsp_in.last       = at_end;
            end
            default: rsp_in.status = ctrl.rsp_status;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
      rsp_ff <= rsp_in;
   end

   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

[hdl/tmcs_ctrl.sv]
// ----------------------------------------------------------------------------
// tmcs_ctrl
// Controller: sequences the clearing sweep, the request checks and the
// memory accesses of each command, and loads response words.
// ----------------------------------------------------------------------------
module tmcs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tmcs_pkg::stat_type  stat,
   output tmcs_pkg::ctrl_type  ctrl
);

   tmcs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= tmcs_pkg::S_CLEAR;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in        = state_ff;
      ctrl            = '0;
      ctrl.rsp_sel    = tmcs_pkg::RSP_STATUS;
      ctrl.rsp_status = tmcs_pkg::STAT_OK;
      req_ready       = 1'b0;
      case (state_ff)
         tmcs_pkg::S_CLEAR: begin
            ctrl.clear = 1'b1;
            if (stat.clear_done)
               state_in = tmcs_pkg::S_IDLE;
         end
         tmcs_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
            if (req_valid)
               state_in = tmcs_pkg::S_BASE;
         end
         tmcs_pkg::S_BASE: begin
            ctrl.base_load = 1'b1;
            state_in       = tmcs_pkg::S_EVAL;
         end
         tmcs_pkg::S_EVAL: begin
            case (stat.cmd)
               tmcs_pkg::CMD_WRITE_CELL: begin
                  if (stat.cell_oob || stat.layer_bad) begin
                     ctrl.rsp_status = stat.cell_oob ? tmcs_pkg::STAT_CELL_OOB
                                                     : tmcs_pkg::STAT_LAYER_BAD;
                     ctrl.rsp_load   = stat.rsp_free;
                     if (stat.rsp_free)
                        state_in = tmcs_pkg::S_IDLE;
                  end else begin
                     ctrl.cell_write = 1'b1;
                     ctrl.div_start  = 1'b1;
                     state_in        = tmcs_pkg::S_DIV;
                  end
               end
               tmcs_pkg::CMD_READ_CELL: begin
                  if (stat.cell_oob) begin
                     ctrl.rsp_status = tmcs_pkg::STAT_CELL_OOB;
                     ctrl.rsp_load   = stat.rsp_free;
                     if (stat.rsp_free)
                        state_in = tmcs_pkg::S_IDLE;
                  end else begin
                     ctrl.cell_read = 1'b1;
                     state_in       = tmcs_pkg::S_CELL_OUT;
                  end
               end
               tmcs_pkg::CMD_READ_CHUNK: begin
                  if (stat.chunk_oob) begin
                     ctrl.rsp_status = tmcs_pkg::STAT_CHUNK_OOB;
                     ctrl.rsp_load   = stat.rsp_free;
                     if (stat.rsp_free)
                        state_in = tmcs_pkg::S_IDLE;
                  end else begin
                     ctrl.chunk_start = 1'b1;
                     state_in         = tmcs_pkg::S_CHUNK;
                  end
               end
               tmcs_pkg::CMD_READ_GEN: begin
                  if (stat.chunk_oob) begin
                     ctrl.rsp_status = tmcs_pkg::STAT_CHUNK_OOB;
                     ctrl.rsp_load   = stat.rsp_free;
                     if (stat.rsp_free)
                        state_in = tmcs_pkg::S_IDLE;
                  end else begin
                     ctrl.gen_read_cmd = 1'b1;
                     state_in          = tmcs_pkg::S_GEN_OUT;
                  end
               end
               default: state_in = tmcs_pkg::S_IDLE;
            endcase
         end
         tmcs_pkg::S_DIV: begin
            if (stat.div_done)
               state_in = tmcs_pkg::S_GEN_RD;
         end
         tmcs_pkg::S_GEN_RD: begin
            ctrl.gen_read_rmw = 1'b1;
            state_in          = tmcs_pkg::S_GEN_WR;
         end
         tmcs_pkg::S_GEN_WR: begin
            if (stat.rsp_free) begin
               ctrl.gen_inc  = 1'b1;
               ctrl.rsp_load = 1'b1;
               state_in      = tmcs_pkg::S_IDLE;
            end
         end
         tmcs_pkg::S_CELL_OUT: begin
            ctrl.rsp_sel = tmcs_pkg::RSP_CELL;
            if (stat.rsp_free) begin
               ctrl.rsp_load = 1'b1;
               state_in      = tmcs_pkg::S_IDLE;
            end
         end
         tmcs_pkg::S_GEN_OUT: begin
            ctrl.rsp_sel = tmcs_pkg::RSP_GEN;
            if (stat.rsp_free) begin
               ctrl.rsp_load = 1'b1;
               state_in      = tmcs_pkg::S_IDLE;
            end
         end
         tmcs_pkg::S_CHUNK: begin
            ctrl.rsp_sel = tmcs_pkg::RSP_CHUNK;
            if (stat.rsp_free) begin
               ctrl.rsp_load = 1'b1;
               if (stat.chunk_end)
                  state_in = tmcs_pkg::S_IDLE;
               else
                  ctrl.chunk_adv = 1'b1;
            end
         end
         default: state_in = tmcs_pkg::S_IDLE;
      endcase
   end

endmodule

[hdl/tile_map_chunk_store_top.sv]
// ----------------------------------------------------------------------------
// tile_map_chunk_store_top
// Byte-per-cell tile map with one 64-bit generation counter per chunk.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores to zero, one entry per cycle, and
// takes no request word until the sweep is done; configuration writes are
// taken at any time. Requests are handled one at a time. A read cell word
// or read generation word reads its memory in the check state and loads its
// response in its output state, while an error response is loaded in the
// check state itself. A write cell word runs the six-step divider that finds
// the chunk of the cell, then reads its counter and writes it back plus one.
// A read chunk word loads its first response word in the chunk state and
// then one response word per cycle while the consumer keeps up. The next
// request is taken in the cycle after the final response word is loaded.
// ----------------------------------------------------------------------------
module tile_map_chunk_store_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tmcs_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tmcs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [tmcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tmcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tmcs_pkg::ctrl_type ctrl;
   tmcs_pkg::stat_type stat;

   tmcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   tmcs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/tmcs_checker.sv]
// ----------------------------------------------------------------------------
// tmcs_checker
// Port-level checks of the tile map chunk store, bound to the top level.
// ----------------------------------------------------------------------------
module tmcs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input tmcs_pkg::rsp_type                 rsp_data
);

   // The clearing sweep holds off requests right after reset.
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during clearing sweep");

   // Only one request is in the block at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // Error responses end their command.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != tmcs_pkg::STAT_OK |-> rsp_data.last &&
      rsp_data.cell_value == '0 && rsp_data.generation == '0)
      else $error("error response word is not a plain final word");

   // A counter value only comes with a good single-word generation read.
   a_gen_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.generation != '0 |-> rsp_data.last &&
      rsp_data.cell_value == '0)
      else $error("generation value mixed with cell data");

endmodule

bind tile_map_chunk_store_top tmcs_checker u_tmcs_checker (.*);

[bench/tile_map_chunk_store_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_map_chunk_store_top_tb
// Self-checking bench for the tile map chunk store. A driver offers request
// words from a queue and keeps a mirror of the cell store, the chunk counters
// and the registers. From that mirror it works out the response words that
// each accepted request must give. A monitor compares every response word,
// field by field, with the oldest expected word. A short directed part is
// followed by random phases, each under its own register setting, with
// random gaps on both channels in all but one phase and one long response hold-off.
// ----------------------------------------------------------------------------
module tile_map_chunk_store_top_tb;
   import tmcs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_type pending_requests[$];
   rsp_type expected_responses[$];
   rsp_type oldest_response;

   logic [CELL_W-1:0] cell_mirror[MEM_DEPTH] = '{default: '0};
   logic [GEN_W-1:0] gen_mirror[MEM_DEPTH] = '{default: '0};

   logic [DIM_W-1:0] cfg_map_w = 7'd64;
   logic [DIM_W-1:0] cfg_map_h = 7'd64;
   logic [CDIM_W-1:0] cfg_chunk_w = 4'd8;
   logic [CDIM_W-1:0] cfg_chunk_h = 4'd8;
   logic [LAYER_CNT_W-1:0] cfg_layers = 9'd256;
   int unsigned eff_mw = 64;
   int unsigned eff_mh = 64;
   int unsigned eff_cw = 8;
   int unsigned eff_ch = 8;
   int unsigned chunks_across = 8;
   int unsigned chunks_down = 8;

   bit idling_on = 1'b1;
   bit hold_armed = 1'b0;
   int unsigned hold_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   tile_map_chunk_store_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void regrid_mirror();
      eff_mw = clamp_dim(cfg_map_w, MAX_MAP_DIM);
      eff_mh = clamp_dim(cfg_map_h, MAX_MAP_DIM);
      eff_cw = clamp_dim(cfg_chunk_w, MAX_CHUNK_DIM);
      eff_ch = clamp_dim(cfg_chunk_h, MAX_CHUNK_DIM);
      chunks_across = (eff_mw + eff_cw - 1) / eff_cw;
      chunks_down = (eff_mh + eff_ch - 1) / eff_ch;
   endfunction

   function automatic void predict_tile_responses(input req_type rq);
      int unsigned c;
      int unsigned r;
      int unsigned wr;
      int unsigned wc;
      int unsigned total;
      int unsigned k;
      rsp_type word;
      c = rq.col;
      r = rq.row;
      word = '0;
      word.last = 1'b1;
      if (rq.cmd == CMD_WRITE_CELL || rq.cmd == CMD_READ_CELL) begin
         if (c >= eff_mw || r >= eff_mh) begin
            word.status = STAT_CELL_OOB;
         end else if (rq.cmd == CMD_READ_CELL) begin
            word.cell_value = cell_mirror[r * MAX_MAP_DIM + c];
         end else if (rq.layer_value >= cfg_layers) begin
            word.status = STAT_LAYER_BAD;
         end else begin
            cell_mirror[r * MAX_MAP_DIM + c] = rq.layer_value;
            gen_mirror[(r / eff_ch) * MAX_MAP_DIM + c / eff_cw] += 1;
         end
         expected_responses.push_back(word);
      end else if (c >= chunks_across || r >= chunks_down) begin
         word.status = STAT_CHUNK_OOB;
         expected_responses.push_back(word);
      end else if (rq.cmd == CMD_READ_GEN) begin
         word.generation = gen_mirror[r * MAX_MAP_DIM + c];
         expected_responses.push_back(word);
      end else begin
         total = eff_cw * eff_ch;
         k = 0;
         for (int unsigned lr = 0; lr < eff_ch; lr++) begin
            for (int unsigned lc = 0; lc < eff_cw; lc++) begin
               wr = r * eff_ch + lr;
               wc = c * eff_cw + lc;
               word.cell_value = (wr < eff_mh && wc < eff_mw) ?
                                 cell_mirror[wr * MAX_MAP_DIM + wc] : '0;
               k++;
               word.last = (k == total);
               expected_responses.push_back(word);
            end
         end
      end
   endfunction

   function automatic req_type random_request();
      req_type rq;
      int unsigned pick;
      int unsigned layer_top;
      rq.cmd = cmd_type'($urandom_range(0, 3));
      rq.col = 6'($urandom_range(0, 63));
      rq.row = 6'($urandom_range(0, 63));
      rq.layer_value = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 75) begin
         pick = $urandom_range(0, 99);
         rq.cmd = (pick < 35) ? CMD_WRITE_CELL :
                  (pick < 60) ? CMD_READ_CELL :
                  (pick < 80) ? CMD_READ_CHUNK : CMD_READ_GEN;
         if (rq.cmd == CMD_WRITE_CELL || rq.cmd == CMD_READ_CELL) begin
            rq.col = 6'($urandom_range(0, eff_mw - 1));
            rq.row = 6'($urandom_range(0, eff_mh - 1));
         end else begin
            rq.col = 6'($urandom_range(0, chunks_across - 1));
            rq.row = 6'($urandom_range(0, chunks_down - 1));
         end
         if (cfg_layers != 0) begin
            layer_top = (cfg_layers > 256) ? 256 : cfg_layers;
            rq.layer_value = 8'($urandom_range(0, layer_top - 1));
         end
      end
      return rq;
   endfunction

   function automatic void push_req(input cmd_type cmd, input int unsigned col,
                                    input int unsigned row, input int unsigned layer);
      req_type rq;
      rq.cmd = cmd;
      rq.col = 6'(col);
      rq.row = 6'(row);
      rq.layer_value = 8'(layer);
      pending_requests.push_back(rq);
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [8:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MAP_WIDTH: cfg_map_w = value[6:0];
         CSR_MAP_HEIGHT: cfg_map_h = value[6:0];
         CSR_CHUNK_WIDTH: cfg_chunk_w = value[3:0];
         CSR_CHUNK_HEIGHT: cfg_chunk_h = value[3:0];
         CSR_LAYER_COUNT: cfg_layers = value;
         default: ;
      endcase
      regrid_mirror();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic start_phase(input int unsigned mw, input int unsigned mh,
                              input int unsigned cw, input int unsigned ch,
                              input int unsigned lc);
      wait_drained();
      write_register(CSR_MAP_WIDTH, 9'(mw));
      write_register(CSR_MAP_HEIGHT, 9'(mh));
      write_register(CSR_CHUNK_WIDTH, 9'(cw));
      write_register(CSR_CHUNK_HEIGHT, 9'(ch));
      write_register(CSR_LAYER_COUNT, 9'(lc));
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) pending_requests.push_back(random_request());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_tile_responses(req_data);
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && !(idling_on && $urandom_range(0, 99) < 31)) begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $error("response word arrived with nothing expected");
               mismatch_count++;
            end else begin
               oldest_response = expected_responses.pop_front();
               if (rsp_data.status != oldest_response.status) begin
                  $error("status: expected %0d actual %0d",
                         oldest_response.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.cell_value != oldest_response.cell_value) begin
                  $error("cell_value: expected %0d actual %0d",
                         oldest_response.cell_value, rsp_data.cell_value);
                  mismatch_count++;
               end
               if (rsp_data.generation != oldest_response.generation) begin
                  $error("generation: expected %0d actual %0d",
                         oldest_response.generation, rsp_data.generation);
                  mismatch_count++;
               end
               if (rsp_data.last != oldest_response.last) begin
                  $error("last: expected %0d actual %0d",
                         oldest_response.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
         end
         rsp_ready <= (hold_left == 0) && !(idling_on && $urandom_range(0, 99) < 31);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** tile_map_chunk_store_top: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Corners of the full-size map under the reset setting.
      push_req(CMD_WRITE_CELL, 0, 0, 0);
      push_req(CMD_WRITE_CELL, 63, 63, 255);
      push_req(CMD_WRITE_CELL, 63, 0, 170);
      push_req(CMD_WRITE_CELL, 0, 63, 85);
      push_req(CMD_READ_CELL, 0, 0, 0);
      push_req(CMD_READ_CELL, 63, 63, 0);
      push_req(CMD_READ_CELL, 63, 0, 0);
      push_req(CMD_READ_CHUNK, 0, 0, 0);
      push_req(CMD_READ_CHUNK, 7, 7, 0);
      push_req(CMD_READ_GEN, 7, 7, 0);
      push_req(CMD_READ_GEN, 7, 0, 0);
      push_req(CMD_READ_GEN, 0, 8, 0);
      push_req(CMD_READ_CHUNK, 63, 63, 0);

      // Odd map and chunk sizes: edge padding, both errors of a write and
      // the cell check taking precedence over the layer check.
      start_phase(40, 20, 3, 5, 100);
      push_req(CMD_WRITE_CELL, 39, 19, 99);
      push_req(CMD_WRITE_CELL, 40, 0, 7);
      push_req(CMD_WRITE_CELL, 0, 20, 7);
      push_req(CMD_WRITE_CELL, 45, 25, 200);
      push_req(CMD_WRITE_CELL, 5, 5, 100);
      push_req(CMD_READ_CELL, 40, 3, 0);
      push_req(CMD_READ_CELL, 39, 19, 0);
      push_req(CMD_READ_CHUNK, 13, 3, 0);
      push_req(CMD_READ_CHUNK, 14, 0, 0);
      push_req(CMD_READ_GEN, 13, 3, 0);
      push_req(CMD_READ_GEN, 0, 4, 0);

      start_phase(64, 64, 8, 8, 256);
      queue_random(50);
      start_phase(1, 1, 1, 1, 1);
      queue_random(40);
      start_phase(0, 0, 0, 0, 0);
      queue_random(40);
      start_phase(127, 127, 15, 15, 511);
      hold_armed = 1'b1;
      queue_random(50);
      for (int p = 0; p < 5; p++) begin
         start_phase($urandom_range(1, 64), $urandom_range(1, 64),
                     $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 300));
         idling_on = (p != 2);
         queue_random(54);
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("** tile_map_chunk_store_top: PASSED **");
      end else begin
         $display("** tile_map_chunk_store_top: FAILED **");
      end
      $finish;
   end

endmodule
